// ===== rtl/face_track_attribute_tally_top_macros.svh =====
// ----------------------------------------------------------------------------
// Face track attribute tally: assertion macros
// Shorthands for the concurrent checks in the tally block, clocked on clk and
// disabled during rst.
// ----------------------------------------------------------------------------
`ifndef FACE_TRACK_ATTRIBUTE_TALLY_TOP_MACROS_SVH
`define FACE_TRACK_ATTRIBUTE_TALLY_TOP_MACROS_SVH

// Condition holds at every edge out of reset
`define FTAT_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent holds at the same edge as the antecedent
`define FTAT_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent holds at the next edge after the antecedent
`define FTAT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/ftat_pkg.sv =====
// ----------------------------------------------------------------------------
// Face track attribute tally: shared package
// Beat types for the face and tally channels, default parameter values and
// named codes for tally slots and gender.
// ----------------------------------------------------------------------------
package ftat_pkg;

  // Fixed field widths of the channel beats
  localparam int BOX_BITS       = 12;
  localparam int AREA_BITS      = 24;
  localparam int AGE_FIELD_BITS = 3;
  localparam int OUT_BITS       = 16;
  localparam int VOTE_BITS      = 16;
  localparam int MISSED_BITS    = 8;
  localparam int NUM_OUT        = 8;

  // Parameter defaults
  localparam int COORD_BITS_DEF = 12;
  localparam int TALLY_BITS_DEF = 16;
  localparam int AGE_GROUPS_DEF = 5;

  // Reset value of the missed-frames limit
  localparam logic [MISSED_BITS-1:0] MISSED_LIMIT_RESET = 8'd1;

  // Tally slots
  localparam int TALLY_PEOPLE = 0;
  localparam int TALLY_FEMALE = 1;
  localparam int TALLY_MALE   = 2;
  localparam int TALLY_AGE0   = 3;

  // Gender codes
  localparam logic GENDER_FEMALE = 1'b0;
  localparam logic GENDER_MALE   = 1'b1;

  typedef struct packed {
    logic                      face_present;
    logic                      face_classified;
    logic [BOX_BITS-1:0]       box_left;
    logic [BOX_BITS-1:0]       box_top;
    logic [BOX_BITS-1:0]       box_right;
    logic [BOX_BITS-1:0]       box_bottom;
    logic [AREA_BITS-1:0]      box_area;
    logic                      gender;
    logic [AGE_FIELD_BITS-1:0] age_group;
    logic                      last_of_frame;
  } item_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] people_total;
    logic [OUT_BITS-1:0] female_total;
    logic [OUT_BITS-1:0] male_total;
    logic [OUT_BITS-1:0] child_total;
    logic [OUT_BITS-1:0] teen_total;
    logic [OUT_BITS-1:0] young_total;
    logic [OUT_BITS-1:0] middle_total;
    logic [OUT_BITS-1:0] older_total;
  } result_t;

endpackage

// ===== rtl/face_track_attribute_tally_top.sv =====
// ----------------------------------------------------------------------------
// Face track attribute tally: top level
// Picks the largest classified face of each frame, follows it across frames
// by box overlap, collects gender and age votes and tallies finished faces.
// ----------------------------------------------------------------------------
// Throughput: one face beat per cycle, except that a last-of-frame beat stalls
//   behind a blocked frame end; the pick compare and the tracker update each
//   sit in their own register stage. A last-of-frame beat reaches its tally beat
//   through the input register, frame-end register and result register.
// Reset: rst (synchronous) clears tracking, votes, tallies and all valids and
//   sets the missed-frames limit to 1; no clearing pass is needed.
`include "face_track_attribute_tally_top_macros.svh"

module face_track_attribute_tally_top #(
  parameter int COORD_BITS = ftat_pkg::COORD_BITS_DEF,
  parameter int TALLY_BITS = ftat_pkg::TALLY_BITS_DEF,
  parameter int AGE_GROUPS = ftat_pkg::AGE_GROUPS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [ftat_pkg::MISSED_BITS-1:0]       cfg_data,
  input  logic                                   item_valid,
  output logic                                   item_stall,
  input  ftat_pkg::item_t                        item,
  output logic                                   result_valid,
  input  logic                                   result_stall,
  output ftat_pkg::result_t                      result
);
  import ftat_pkg::*;

  localparam int CW          = COORD_BITS;
  localparam int AGE_W       = $clog2(AGE_GROUPS);
  localparam int NUM_TALLIES = 3 + AGE_GROUPS;
  localparam int OV_W        = 2 * COORD_BITS;
  localparam int CMP_W       = ((OV_W > AREA_BITS + 1) ? OV_W : AREA_BITS + 1) + 6;

  // Configuration register
  logic [MISSED_BITS-1:0] max_missed_frames;

  // Input register
  logic  s1_valid;
  item_t s1;

  // Running pick of the current frame
  logic                 frame_start;
  logic                 pick_valid;
  logic [CW-1:0]        pick_box [4];
  logic [AREA_BITS-1:0] pick_area;
  logic                 pick_gender;
  logic [AGE_W-1:0]     pick_age;

  // Frame-end register: final pick of a closed frame
  logic                 s2_valid;
  logic                 s2_pick_valid;
  logic [CW-1:0]        s2_box [4];
  logic [AREA_BITS-1:0] s2_area;
  logic                 s2_gender;
  logic [AGE_W-1:0]     s2_age;

  // Tracker state
  logic                   tracking;
  logic [MISSED_BITS-1:0] missed_count;
  logic [CW-1:0]          track_box [4];
  logic [AREA_BITS-1:0]   track_area;
  logic [VOTE_BITS-1:0]   gender_votes [2];
  logic [VOTE_BITS-1:0]   age_votes [AGE_GROUPS];
  logic [TALLY_BITS-1:0]  tallies [NUM_TALLIES];

  // Handshake control
  logic s2_block;
  logic s2_fire;
  logic s1_fire;

  assign cfg_ready  = 1'b1;
  assign s2_block   = s2_valid && result_valid && result_stall;
  assign s2_fire    = s2_valid && !s2_block;
  assign item_stall = s1_valid && s1.last_of_frame && s2_block;
  assign s1_fire    = s1_valid && !item_stall;

  // Write the missed-frames limit
  always_ff @(posedge clk) begin
    if (rst) begin
      max_missed_frames <= MISSED_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_missed_frames <= cfg_data;
    end
  end

  // Capture an accepted face beat
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!item_stall) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      s1 <= item;
    end
  end

  // ---------------------------------------------------------------- pick
  logic [CW-1:0]        in_box [4];
  logic [AGE_W-1:0]     in_age;
  logic [AREA_BITS-1:0] cmp_area;
  logic                 seed_item;
  logic                 take_item;
  logic                 f_valid;
  logic [CW-1:0]        f_box [4];
  logic [AREA_BITS-1:0] f_area;
  logic                 f_gender;
  logic [AGE_W-1:0]     f_age;

  // Merge the beat into the running pick
  always_comb begin
    in_box[0] = CW'(s1.box_left);
    in_box[1] = CW'(s1.box_top);
    in_box[2] = CW'(s1.box_right);
    in_box[3] = CW'(s1.box_bottom);
    if (32'(s1.age_group) >= AGE_GROUPS) begin
      in_age = AGE_W'(AGE_GROUPS - 1);
    end else begin
      in_age = AGE_W'(s1.age_group);
    end
    cmp_area  = frame_start ? s1.box_area : pick_area;
    seed_item = s1.face_present && frame_start;
    take_item = s1.face_present && s1.face_classified && (s1.box_area >= cmp_area);
    f_valid   = pick_valid || take_item;
    for (int k = 0; k < 4; k++) begin
      f_box[k] = (seed_item || take_item) ? in_box[k] : pick_box[k];
    end
    f_area   = (seed_item || take_item) ? s1.box_area : pick_area;
    f_gender = take_item ? s1.gender : pick_gender;
    f_age    = take_item ? in_age : pick_age;
  end

  // Advance the pick; close the frame on its last beat
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_start <= 1'b1;
      pick_valid  <= 1'b0;
    end else if (s1_fire) begin
      if (s1.last_of_frame) begin
        frame_start <= 1'b1;
        pick_valid  <= 1'b0;
      end else begin
        frame_start <= frame_start && !s1.face_present;
        pick_valid  <= f_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      pick_box    <= f_box;
      pick_area   <= f_area;
      pick_gender <= s1.last_of_frame ? GENDER_FEMALE : f_gender;
      pick_age    <= s1.last_of_frame ? '0 : f_age;
    end
  end

  // Hand the final pick to the frame-end stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (!s2_block) begin
      s2_valid <= s1_fire && s1.last_of_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1.last_of_frame) begin
      s2_pick_valid <= f_valid;
      s2_box        <= f_box;
      s2_area       <= f_area;
      s2_gender     <= f_gender;
      s2_age        <= f_age;
    end
  end

  // ----------------------------------------------------------- frame end
  logic [CW-1:0]           lx, ly, hx, hy;
  logic [OV_W-1:0]         overlap;
  logic signed [CMP_W-1:0] ov_s, un_s, lhs, rhs;
  logic                    same_face;
  logic                    maj_gender;
  logic [AGE_W-1:0]        maj_age;
  logic [VOTE_BITS-1:0]    best_votes;
  logic                    finish;
  logic                    seed_votes;

  // Overlap test: 10 * overlap > 3 * union
  always_comb begin
    lx = (track_box[0] > s2_box[0]) ? track_box[0] : s2_box[0];
    ly = (track_box[1] > s2_box[1]) ? track_box[1] : s2_box[1];
    hx = (track_box[2] < s2_box[2]) ? track_box[2] : s2_box[2];
    hy = (track_box[3] < s2_box[3]) ? track_box[3] : s2_box[3];
    if ((lx < hx) && (ly < hy)) begin
      overlap = OV_W'(hx - lx) * OV_W'(hy - ly);
    end else begin
      overlap = '0;
    end
    ov_s      = $signed(CMP_W'(overlap));
    un_s      = $signed(CMP_W'(track_area)) + $signed(CMP_W'(s2_area)) - ov_s;
    lhs       = (ov_s <<< 3) + (ov_s <<< 1);
    rhs       = (un_s <<< 1) + un_s;
    same_face = lhs > rhs;
  end

  // Majority gender (tie to male) and age group (tie to lowest)
  always_comb begin
    maj_gender = (gender_votes[0] > gender_votes[1]) ? GENDER_FEMALE : GENDER_MALE;
    best_votes = age_votes[0];
    maj_age    = '0;
    for (int i = 1; i < AGE_GROUPS; i++) begin
      if (age_votes[i] > best_votes) begin
        best_votes = age_votes[i];
        maj_age    = AGE_W'(i);
      end
    end
  end

  assign finish = tracking &&
                  (s2_pick_valid ? !same_face : (missed_count >= max_missed_frames));
  assign seed_votes = s2_pick_valid && (!tracking || !same_face);

  logic                   tracking_next;
  logic [MISSED_BITS-1:0] missed_count_next;
  logic [VOTE_BITS-1:0]   gender_votes_next [2];
  logic [VOTE_BITS-1:0]   age_votes_next [AGE_GROUPS];
  logic [TALLY_BITS-1:0]  tallies_next [NUM_TALLIES];
  result_t                result_next;
  logic [OUT_BITS-1:0]    out_vals [NUM_OUT];

  // Tracker next state and tally update
  always_comb begin
    tracking_next     = tracking;
    missed_count_next = missed_count;
    gender_votes_next = gender_votes;
    age_votes_next    = age_votes;
    tallies_next      = tallies;
    if (s2_pick_valid) begin
      tracking_next     = 1'b1;
      missed_count_next = '0;
    end else if (tracking) begin
      if (finish) begin
        tracking_next     = 1'b0;
        missed_count_next = '0;
      end else begin
        missed_count_next = missed_count + 1'b1;
      end
    end
    // Votes: seed, add or drop
    for (int g = 0; g < 2; g++) begin
      if (seed_votes) begin
        gender_votes_next[g] = (g == int'(s2_gender)) ? VOTE_BITS'(1) : '0;
      end else if (s2_pick_valid) begin
        if (g == int'(s2_gender) && !(&gender_votes[g])) begin
          gender_votes_next[g] = gender_votes[g] + 1'b1;
        end
      end else if (finish) begin
        gender_votes_next[g] = '0;
      end
    end
    for (int a = 0; a < AGE_GROUPS; a++) begin
      if (seed_votes) begin
        age_votes_next[a] = (a == int'(s2_age)) ? VOTE_BITS'(1) : '0;
      end else if (s2_pick_valid) begin
        if (a == int'(s2_age) && !(&age_votes[a])) begin
          age_votes_next[a] = age_votes[a] + 1'b1;
        end
      end else if (finish) begin
        age_votes_next[a] = '0;
      end
    end
    // Tally the finished face, saturating
    for (int t = 0; t < NUM_TALLIES; t++) begin
      if (finish && !(&tallies[t]) &&
          ((t == TALLY_PEOPLE) || (t == TALLY_FEMALE + int'(maj_gender)) ||
           (t == TALLY_AGE0 + int'(maj_age)))) begin
        tallies_next[t] = tallies[t] + 1'b1;
      end
    end
    // Map tallies onto the result beat
    for (int j = 0; j < NUM_OUT; j++) begin
      out_vals[j] = '0;
    end
    for (int j = 0; (j < NUM_OUT) && (j < NUM_TALLIES); j++) begin
      out_vals[j] = OUT_BITS'(tallies_next[j]);
    end
    result_next.people_total = out_vals[0];
    result_next.female_total = out_vals[1];
    result_next.male_total   = out_vals[2];
    result_next.child_total  = out_vals[3];
    result_next.teen_total   = out_vals[4];
    result_next.young_total  = out_vals[5];
    result_next.middle_total = out_vals[6];
    result_next.older_total  = out_vals[7];
  end

  // Commit the tracker on each closed frame
  always_ff @(posedge clk) begin
    if (rst) begin
      tracking     <= 1'b0;
      missed_count <= '0;
      for (int g = 0; g < 2; g++) begin
        gender_votes[g] <= '0;
      end
      for (int a = 0; a < AGE_GROUPS; a++) begin
        age_votes[a] <= '0;
      end
      for (int t = 0; t < NUM_TALLIES; t++) begin
        tallies[t] <= '0;
      end
    end else if (s2_fire) begin
      tracking     <= tracking_next;
      missed_count <= missed_count_next;
      gender_votes <= gender_votes_next;
      age_votes    <= age_votes_next;
      tallies      <= tallies_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire && s2_pick_valid) begin
      track_box  <= s2_box;
      track_area <= s2_area;
    end
  end

  // Result register: load when empty or drained
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (!(result_valid && result_stall)) begin
      result_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      result <= result_next;
    end
  end

  // ---------------------------------------------------------- assertions
  `FTAT_ASSERT_IMPLIES(a_idle_no_votes, !tracking, (gender_votes[0] == '0) && (gender_votes[1] == '0) && (missed_count == '0), "votes or missed count left over with no face followed")
  `FTAT_ASSERT_IMPLIES(a_track_has_votes, tracking, (gender_votes[0] != '0) || (gender_votes[1] != '0), "followed face carries no gender vote")
  `FTAT_ASSERT_IMPLIES(a_pick_opens_frame, pick_valid, !frame_start, "pick held while frame still unopened")
  `FTAT_ASSERT_IMPLIES(a_stall_cause, item_stall, s1_valid && s1.last_of_frame && s2_valid, "face beat stalled without a blocked frame end")
  `FTAT_ASSERT_NEXT(a_frame_end_out, s2_fire, result_valid, "closed frame produced no tally beat")

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// Face track attribute tally: testbench
// Drives face beats in frames and predicts the tally beat at every frame end:
// the frame pick, overlap tracking, vote majorities and the missed-frames
// limit. The receiver compares each tally beat field by field, and the run
// goes through several missed-frames limits with random idling on both sides.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ftat_pkg::*;

  localparam int AGES         = AGE_GROUPS_DEF;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 8;

  // Tracker predictor and store of pending tally beats
  class face_tally_scoreboard;
    bit [MISSED_BITS-1:0] miss_limit;
    bit                   tracking;
    bit [MISSED_BITS-1:0] missed;
    bit [BOX_BITS-1:0]    trk_box [4];
    bit [AREA_BITS-1:0]   trk_area;
    bit [VOTE_BITS-1:0]   gender_votes [2];
    bit [VOTE_BITS-1:0]   age_votes [AGES];
    bit [OUT_BITS-1:0]    tallies [NUM_OUT];
    bit                   frame_open;
    bit                   have_pick;
    bit [BOX_BITS-1:0]    cand_box [4];
    bit [AREA_BITS-1:0]   cand_area;
    bit                   cand_gender;
    bit [2:0]             cand_age;
    result_t              tally_q [$];
    int                   fails;
    string field_name [NUM_OUT] = '{"people_total", "female_total", "male_total",
      "child_total", "teen_total", "young_total", "middle_total", "older_total"};

    function new();
      miss_limit = MISSED_LIMIT_RESET;
      tracking   = 1'b0;
      missed     = '0;
      foreach (trk_box[i]) trk_box[i] = '0;
      trk_area = '0;
      foreach (tallies[i]) tallies[i] = '0;
      clear_votes();
      frame_open = 1'b1;
      clear_pick();
      fails = 0;
    endfunction

    function bit [15:0] sat_inc(bit [15:0] v);
      return (&v) ? v : v + 16'd1;
    endfunction

    function void clear_votes();
      foreach (gender_votes[i]) gender_votes[i] = '0;
      foreach (age_votes[i]) age_votes[i] = '0;
    endfunction

    function void clear_pick();
      have_pick = 1'b0;
      foreach (cand_box[i]) cand_box[i] = '0;
      cand_area   = '0;
      cand_gender = 1'b0;
      cand_age    = '0;
    endfunction

    // Start or continue a face from the frame pick
    function void adopt_pick();
      missed = '0;
      gender_votes[cand_gender] = sat_inc(gender_votes[cand_gender]);
      age_votes[cand_age] = sat_inc(age_votes[cand_age]);
      trk_box  = cand_box;
      trk_area = cand_area;
    endfunction

    // Tally a finished face by majority; gender ties go male, age ties low
    function void retire_face();
      int              g_slot;
      int              best_i;
      bit [VOTE_BITS-1:0] best;
      g_slot = (gender_votes[GENDER_FEMALE] > gender_votes[GENDER_MALE]) ?
               TALLY_FEMALE : TALLY_MALE;
      best   = age_votes[0];
      best_i = 0;
      for (int i = 1; i < AGES; i++) begin
        if (age_votes[i] > best) begin
          best   = age_votes[i];
          best_i = i;
        end
      end
      tallies[TALLY_PEOPLE]       = sat_inc(tallies[TALLY_PEOPLE]);
      tallies[g_slot]             = sat_inc(tallies[g_slot]);
      tallies[TALLY_AGE0 + best_i] = sat_inc(tallies[TALLY_AGE0 + best_i]);
      clear_votes();
    endfunction

    // Same face when 10*overlap > 3*union, union taken signed as is
    function bit overlaps_track();
      longint lx, ly, hx, hy, ov, un;
      lx = longint'((trk_box[0] > cand_box[0]) ? trk_box[0] : cand_box[0]);
      ly = longint'((trk_box[1] > cand_box[1]) ? trk_box[1] : cand_box[1]);
      hx = longint'((trk_box[2] < cand_box[2]) ? trk_box[2] : cand_box[2]);
      hy = longint'((trk_box[3] < cand_box[3]) ? trk_box[3] : cand_box[3]);
      ov = 0;
      if (lx < hx && ly < hy) ov = (hx - lx) * (hy - ly);
      un = longint'(trk_area) + longint'(cand_area) - ov;
      return (10 * ov) > (3 * un);
    endfunction

    function void close_frame();
      if (!tracking) begin
        if (have_pick) begin
          tracking = 1'b1;
          clear_votes();
          adopt_pick();
        end
      end else if (!have_pick) begin
        if (missed < miss_limit) begin
          missed = missed + 1'b1;
        end else begin
          retire_face();
          tracking = 1'b0;
          missed   = '0;
        end
      end else if (overlaps_track()) begin
        adopt_pick();
      end else begin
        retire_face();
        adopt_pick();
      end
    endfunction

    // Fold one accepted face beat into the frame; queue the tallies at frame end
    function void note_face(item_t it);
      bit [BOX_BITS-1:0] b [4];
      bit [2:0]          age;
      result_t           r;
      b[0] = it.box_left;
      b[1] = it.box_top;
      b[2] = it.box_right;
      b[3] = it.box_bottom;
      age  = (it.age_group >= AGES) ? 3'(AGES - 1) : it.age_group;
      if (it.face_present) begin
        if (frame_open) begin
          cand_box   = b;
          cand_area  = it.box_area;
          frame_open = 1'b0;
        end
        if (it.face_classified && it.box_area >= cand_area) begin
          have_pick   = 1'b1;
          cand_box    = b;
          cand_area   = it.box_area;
          cand_gender = it.gender;
          cand_age    = age;
        end
      end
      if (!it.last_of_frame) return;
      close_frame();
      frame_open = 1'b1;
      clear_pick();
      r.people_total = tallies[TALLY_PEOPLE];
      r.female_total = tallies[TALLY_FEMALE];
      r.male_total   = tallies[TALLY_MALE];
      r.child_total  = tallies[TALLY_AGE0];
      r.teen_total   = tallies[TALLY_AGE0 + 1];
      r.young_total  = tallies[TALLY_AGE0 + 2];
      r.middle_total = tallies[TALLY_AGE0 + 3];
      r.older_total  = tallies[TALLY_AGE0 + 4];
      tally_q.push_back(r);
    endfunction

    function void note_fail(string msg);
      fails++;
      if (fails <= 10) $display("%0t ns: %s", $realtime, msg);
    endfunction

    // Compare a received tally beat with the oldest pending one
    function void check_tally(result_t got);
      result_t           want;
      bit [OUT_BITS-1:0] w;
      logic [OUT_BITS-1:0] g;
      if (tally_q.size() == 0) begin
        note_fail($sformatf("tally beat with none pending: %h", got));
        return;
      end
      want = tally_q.pop_front();
      for (int k = 0; k < NUM_OUT; k++) begin
        w = want[(NUM_OUT - 1 - k) * OUT_BITS +: OUT_BITS];
        g = got[(NUM_OUT - 1 - k) * OUT_BITS +: OUT_BITS];
        if (g !== w) begin
          note_fail($sformatf("%s: expected %0d, got %0d", field_name[k], w, g));
        end
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [MISSED_BITS-1:0] cfg_data = '0;
  logic                   item_valid = 1'b0;
  logic                   item_stall;
  item_t                  item = '0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  result_t                result;

  face_tally_scoreboard board;
  int  beats_sent = 0;
  int  idle_cycles = 0;
  int  rx_hold = 0;
  int  stall_draw;
  bit  tx_calm = 1'b0;
  bit  rx_calm = 1'b0;
  int  sx = 200, sy = 200, sw = 120, sh = 140;
  bit  sg = 1'b0;
  int  sa = 2;

  face_track_attribute_tally_top uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always #1 clk = ~clk;

  // Receive tally beats; draw a stall after each, with calm stretches
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      rx_hold      <= 0;
    end else if (result_valid && !result_stall) begin
      board.check_tally(result);
      if ($urandom_range(0, 19) == 0) rx_calm = !rx_calm;
      stall_draw = rx_calm ? 0 : $urandom_range(0, 12);
      rx_hold      <= stall_draw;
      result_stall <= (stall_draw != 0);
    end else if (rx_hold != 0) begin
      rx_hold      <= rx_hold - 1;
      result_stall <= (rx_hold != 1);
    end
  end

  // Abort when no beat moves on any channel for too long
  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("face_track_attribute_tally_top: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic item_t face_beat(bit cls, int l, int t, int r, int b, int area,
                                      bit g, int age, bit last);
    item_t it;
    it.face_present    = 1'b1;
    it.face_classified = cls;
    it.box_left        = l[BOX_BITS-1:0];
    it.box_top         = t[BOX_BITS-1:0];
    it.box_right       = r[BOX_BITS-1:0];
    it.box_bottom      = b[BOX_BITS-1:0];
    it.box_area        = area[AREA_BITS-1:0];
    it.gender          = g;
    it.age_group       = age[AGE_FIELD_BITS-1:0];
    it.last_of_frame   = last;
    return it;
  endfunction

  // Empty beat with random leftovers in the ignored fields
  function automatic item_t empty_beat(bit last);
    logic [95:0] raw;
    item_t       it;
    raw = {$urandom, $urandom, $urandom};
    it  = item_t'(raw[$bits(item_t)-1:0]);
    it.face_present  = 1'b0;
    it.last_of_frame = last;
    return it;
  endfunction

  // Send one face beat after a random gap; keep valid high across gapless beats
  task automatic send_beat(item_t it);
    int gap;
    if ($urandom_range(0, 24) == 0) tx_calm = !tx_calm;
    gap = tx_calm ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item       <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    board.note_face(it);
    if (it.face_present || it.last_of_frame) beats_sent++;
  endtask

  // Drain all tally beats, let the pipe settle, then write the missed limit
  task automatic write_limit(bit [MISSED_BITS-1:0] v);
    item_valid <= 1'b0;
    while (board.tally_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    board.miss_limit = v;
  endtask

  // Random frames: mostly one drifting face among distractors, some gaps,
  // replacements and raw noise
  task automatic play_frames(int target);
    item_t       frame_q [$];
    item_t       it;
    logic [95:0] raw;
    int          stop, kind, nd, l, t, w, h;
    stop = beats_sent + target;
    while (beats_sent < stop) begin
      frame_q.delete();
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        repeat ($urandom_range(1, 3)) begin
          raw = {$urandom, $urandom, $urandom};
          frame_q.push_back(item_t'(raw[$bits(item_t)-1:0]));
        end
      end else if (kind < 22) begin
        frame_q.push_back(empty_beat(1'b1));
      end else begin
        if (kind < 34) begin
          // A new face enters the scene
          sw = $urandom_range(16, 300);
          sh = $urandom_range(16, 300);
          sx = $urandom_range(0, 4095 - sw);
          sy = $urandom_range(0, 4095 - sh);
          sg = 1'($urandom_range(0, 1));
          sa = $urandom_range(0, 4);
        end else begin
          // Drift the current face a few pixels
          sx = sx + int'($urandom_range(0, 12)) - 6;
          sy = sy + int'($urandom_range(0, 12)) - 6;
          if (sx < 0) sx = 0;
          if (sy < 0) sy = 0;
          if (sx > 4095 - sw) sx = 4095 - sw;
          if (sy > 4095 - sh) sy = 4095 - sh;
        end
        nd = $urandom_range(0, 2);
        for (int i = 0; i < nd; i++) begin
          w = $urandom_range(4, sw);
          h = $urandom_range(4, sh);
          l = $urandom_range(0, 4095 - w);
          t = $urandom_range(0, 4095 - h);
          frame_q.push_back(face_beat(1'($urandom_range(0, 1)), l, t, l + w, t + h, w * h,
                                      1'($urandom_range(0, 1)), $urandom_range(0, 7), 1'b0));
        end
        if ($urandom_range(0, 7) != 0) begin
          it = face_beat($urandom_range(0, 9) != 0, sx, sy, sx + sw, sy + sh,
                         sw * sh + $urandom_range(0, 40),
                         ($urandom_range(0, 3) == 0) ? 1'($urandom_range(0, 1)) : sg,
                         ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : sa, 1'b0);
          frame_q.insert($urandom_range(0, frame_q.size()), it);
        end
        if ($urandom_range(0, 5) == 0) begin
          frame_q.insert($urandom_range(0, frame_q.size()), empty_beat(1'b0));
        end
        if (frame_q.size() == 0 || $urandom_range(0, 4) == 0) begin
          frame_q.push_back(empty_beat(1'b1));
        end else begin
          frame_q[frame_q.size() - 1].last_of_frame = 1'b1;
        end
      end
      foreach (frame_q[i]) send_beat(frame_q[i]);
    end
  endtask

  initial begin
    board = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed frames at the reset limit of one missed frame
    send_beat(empty_beat(1'b1));
    // Start a face: full area, age out of range
    send_beat(face_beat(1'b1, 100, 100, 300, 300, 24'hFFFFFF, 1'b1, 7, 1'b1));
    // Little overlap against the huge area: replace the face
    send_beat(face_beat(1'b1, 104, 98, 304, 302, 40000, 1'b0, 1, 1'b1));
    // Same face: gender tie and age tie
    send_beat(face_beat(1'b1, 106, 100, 306, 300, 40000, 1'b1, 2, 1'b1));
    // Unclassified only: no pick, one miss
    send_beat(face_beat(1'b0, 106, 100, 306, 300, 40000, 1'b0, 0, 1'b1));
    // Second miss reaches the limit: finish the face
    send_beat(empty_beat(1'b1));
    // Unclassified seed sets the bar; smaller classified loses, equal wins
    send_beat(empty_beat(1'b0));
    send_beat(face_beat(1'b0, 500, 500, 600, 600, 5000, 1'b0, 0, 1'b0));
    send_beat(face_beat(1'b1, 520, 520, 540, 540, 100, 1'b1, 3, 1'b0));
    send_beat(face_beat(1'b1, 510, 510, 590, 590, 5000, 1'b0, 3, 1'b1));
    // Degenerate box replaces the face
    send_beat(face_beat(1'b1, 3000, 3000, 2000, 2000, 50, 1'b0, 5, 1'b1));
    // Full-frame box with zero area
    send_beat(face_beat(1'b1, 0, 0, 4095, 4095, 0, 1'b0, 0, 1'b1));
    // Same box again: negative union still matches
    send_beat(face_beat(1'b1, 0, 0, 4095, 4095, 0, 1'b1, 6, 1'b1));
    // Inverted full box: zero overlap and zero union
    send_beat(face_beat(1'b1, 4095, 4095, 0, 0, 0, 1'b1, 4, 1'b1));
    // Classified seed keeps the pick against a smaller later face
    send_beat(face_beat(1'b1, 10, 10, 20, 20, 24'hFFFFFF, 1'b0, 2, 1'b0));
    send_beat(face_beat(1'b1, 12, 12, 22, 22, 24'hFFFFFE, 1'b1, 1, 1'b1));
    send_beat(empty_beat(1'b1));
    send_beat(empty_beat(1'b1));

    // Random phases across the limit range
    write_limit(8'd0);
    play_frames(140);
    write_limit(8'd255);
    play_frames(140);
    write_limit(8'($urandom_range(2, 6)));
    play_frames(140);

    // Drain and let the pipe settle
    item_valid <= 1'b0;
    while (board.tally_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.fails == 0 && board.tally_q.size() == 0) begin
      $display("face_track_attribute_tally_top: match");
    end else begin
      $display("face_track_attribute_tally_top: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/ftat_pkg.sv
rtl/face_track_attribute_tally_top.sv
bench/tb.sv
